// ----- src/uart_baud_divisor_solver_unit_macros.svh -----
// Assertion macros for the serial-port baud divisor solver.
// Has no dependencies; it is included by the files that carry assertions.
`ifndef UART_BAUD_DIVISOR_SOLVER_UNIT_MACROS_SVH
`define UART_BAUD_DIVISOR_SOLVER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UBDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds after the antecedent, delayed by the lat argument.
`define UBDS_ASSERT_AFTER(label, clk, rst_n, ante, lat, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##lat (cons)) else $error(msg);

`endif

// ----- src/uart_bds_pkg.sv -----
// Package for the serial-port baud divisor solver: field widths and defaults.
// Has no dependencies; it is used by the solver's top level.
package uart_bds_pkg;

    localparam int unsigned BAUD_W             = 32;
    localparam int unsigned CLK_W              = 32;
    localparam int unsigned SEL_W              = 2;
    localparam int unsigned DIV_W              = 8;
    localparam int unsigned FACTOR_BASE_LOG2   = 5;
    localparam int unsigned MAX_PRESCALE       = 4;
    localparam int unsigned DEF_DIVISOR_LIMIT  = 255;
    localparam int unsigned DEF_PRESCALE_COUNT = 4;
    localparam logic [CLK_W-1:0] CLK_HZ_RESET  = CLK_W'(48000000);

endpackage

// ----- src/uart_baud_divisor_solver_unit.sv -----
// Each prescaler lane runs a restoring division: a load stage, an overflow check stage,
// then one quotient bit per stage. A request is taken when start is high and busy is
// low and passes these stages and the output register; one per cycle while busy is low.
// Reset is synchronous and active low: it empties the pipeline, raises busy while held
// and sets the clock register to 48 MHz.
`include "uart_baud_divisor_solver_unit_macros.svh"

module uart_baud_divisor_solver_unit #(
    parameter int unsigned DIVISOR_LIMIT  = uart_bds_pkg::DEF_DIVISOR_LIMIT,
    parameter int unsigned PRESCALE_COUNT = uart_bds_pkg::DEF_PRESCALE_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [uart_bds_pkg::BAUD_W-1:0]  i_baud_rate,
    input  logic                             i_cfg_wr_en,
    input  logic [uart_bds_pkg::CLK_W-1:0]   i_cfg_wr_data,
    output logic                             o_result_valid,
    output logic                             o_found,
    output logic [uart_bds_pkg::SEL_W-1:0]   o_prescale_select,
    output logic [uart_bds_pkg::DIV_W-1:0]   o_divisor_value
);
    import uart_bds_pkg::*;

    localparam int unsigned LANES = (PRESCALE_COUNT > MAX_PRESCALE) ? MAX_PRESCALE
                                                                     : PRESCALE_COUNT;
    localparam int unsigned QW    = $clog2(DIVISOR_LIMIT + 2);
    localparam int unsigned DW    = BAUD_W + FACTOR_BASE_LOG2 + 2 * (LANES - 1);
    localparam int unsigned CW    = DW + QW + 1;
    localparam int unsigned NSTG  = QW + 2;
    localparam int unsigned QXW   = (QW > DIV_W) ? QW : DIV_W;
    localparam int unsigned LAT   = NSTG + 1;

    typedef logic [CW-1:0] t_wide;
    typedef logic [QW-1:0] t_quo;

    logic [CLK_W-1:0] r_clk_hz;
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  n_vld;
    t_wide            r_rem [NSTG][LANES];
    t_wide            n_rem [NSTG][LANES];
    t_wide            r_den [NSTG][LANES];
    t_wide            n_den [NSTG][LANES];
    t_quo             r_quo [NSTG][LANES];
    t_quo             n_quo [NSTG][LANES];
    logic             r_ovf [NSTG][LANES];
    logic             n_ovf [NSTG][LANES];

    logic             r_out_vld;
    logic             r_found;
    logic             n_found;
    logic [SEL_W-1:0] r_sel;
    logic [SEL_W-1:0] n_sel;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] n_div;

    assign busy = ~i_rst_n;

    always_comb begin
        int    k;
        t_wide shifted;
        n_vld = {r_vld[NSTG-2:0], start & ~busy};
        for (int l = 0; l < LANES; l++) begin
            n_den[0][l] = CW'(i_baud_rate) << (FACTOR_BASE_LOG2 + 2 * l);
            n_rem[0][l] = CW'(r_clk_hz)
                        + (CW'(i_baud_rate) << (FACTOR_BASE_LOG2 - 1 + 2 * l));
            n_quo[0][l] = '0;
            n_ovf[0][l] = 1'b0;
        end
        for (int s = 1; s < NSTG; s++) begin
            k = QW - s + 1;
            for (int l = 0; l < LANES; l++) begin
                shifted     = r_den[s-1][l] << k;
                n_den[s][l] = r_den[s-1][l];
                n_rem[s][l] = r_rem[s-1][l];
                n_quo[s][l] = r_quo[s-1][l];
                n_ovf[s][l] = r_ovf[s-1][l];
                if (s == 1) begin
                    n_ovf[s][l] = (r_rem[s-1][l] >= shifted);
                end else if (r_rem[s-1][l] >= shifted) begin
                    n_rem[s][l] = r_rem[s-1][l] - shifted;
                    n_quo[s][l] = r_quo[s-1][l] | (QW'(1) << k);
                end
            end
        end
    end

    always_comb begin
        logic [QXW-1:0] qx;
        n_found = 1'b0;
        n_sel   = '0;
        n_div   = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            qx = QXW'(r_quo[NSTG-1][l]) - QXW'(1);
            if (!r_ovf[NSTG-1][l] && (r_quo[NSTG-1][l] != '0)
                    && (qx <= QXW'(DIVISOR_LIMIT))) begin
                n_found = 1'b1;
                n_sel   = SEL_W'(l);
                n_div   = qx[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz  <= CLK_HZ_RESET;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_clk_hz <= i_cfg_wr_data;
            end
            r_vld     <= n_vld;
            r_out_vld <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_quo   <= n_quo;
        r_ovf   <= n_ovf;
        r_found <= n_found;
        r_sel   <= n_sel;
        r_div   <= n_div;
    end

    assign o_result_valid    = r_out_vld;
    assign o_found           = r_found;
    assign o_prescale_select = r_sel;
    assign o_divisor_value   = r_div;

    `UBDS_ASSERT_AFTER(a_request_to_result, i_clk, i_rst_n, start && !busy, LAT, o_result_valid, "Request did not produce a result at the expected latency.")
    `UBDS_ASSERT_AFTER(a_zero_baud_not_found, i_clk, i_rst_n, start && !busy && (i_baud_rate == '0), LAT, o_result_valid && !o_found, "A zero baud request reported a divisor.")
    `UBDS_ASSERT_IMPL(a_not_found_clear, i_clk, i_rst_n, o_result_valid && !o_found, (o_prescale_select == '0) && (o_divisor_value == '0), "A not-found result carries non-zero fields.")

endmodule

// ----- tb/tb_uart_baud_divisor_solver_unit.sv -----
// Self-checking testbench for the serial-port baud divisor solver, with no other files.
// It uses uart_bds_pkg and the top level uart_baud_divisor_solver_unit.
// Requests go in through the start/busy handshake and each result is checked.
module tb_uart_baud_divisor_solver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import uart_bds_pkg::*;

    localparam int unsigned PIPE_LATENCY = $clog2(DEF_DIVISOR_LIMIT + 2) + 3;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned PHASE_ITEMS  = 104;

    typedef enum logic [SEL_W-1:0] {
        PRESCALE_32,
        PRESCALE_128,
        PRESCALE_512,
        PRESCALE_2048
    } prescale_e;

    typedef enum logic [1:0] {
        ITEM_REQUEST,
        ITEM_CLOCK_WRITE,
        ITEM_DRAIN
    } item_kind_e;

    typedef struct packed {
        logic             found;
        prescale_e        sel;
        logic [DIV_W-1:0] div;
    } divisor_choice_t;

    typedef struct {
        item_kind_e  kind;
        logic [31:0] value;
        int unsigned gap;
    } pending_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [BAUD_W-1:0] i_baud_rate = '0;
    logic              i_cfg_wr_en = 1'b0;
    logic [CLK_W-1:0]  i_cfg_wr_data = '0;
    logic              o_result_valid;
    logic              o_found;
    logic [SEL_W-1:0]  o_prescale_select;
    logic [DIV_W-1:0]  o_divisor_value;

    pending_t          pending_q[$];
    divisor_choice_t   expected_q[$];
    logic [CLK_W-1:0]  model_clk_hz = CLK_HZ_RESET;
    int unsigned       gap_left = 0;
    int unsigned       issued_gap = 0;
    int unsigned       requests_sent = 0;
    int unsigned       results_seen = 0;
    int unsigned       found_seen = 0;
    int unsigned       clock_writes = 0;
    int unsigned       drains_done = 0;
    int unsigned       fail_cnt = 0;
    int unsigned       stall_cycles = 0;
    logic              calm = 1'b0;

    uart_baud_divisor_solver_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_baud_rate       (i_baud_rate),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_result_valid    (o_result_valid),
        .o_found           (o_found),
        .o_prescale_select (o_prescale_select),
        .o_divisor_value   (o_divisor_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic divisor_choice_t solve_divisor(input logic [CLK_W-1:0] clk_hz,
                                                      input logic [BAUD_W-1:0] baud);
        divisor_choice_t choice;
        logic [63:0]     denom;
        logic [63:0]     quot;
        choice = '0;
        for (int s = 0; s < MAX_PRESCALE; s++) begin
            denom = 64'(baud) << (FACTOR_BASE_LOG2 + 2 * s);
            if (!choice.found && denom != 0) begin
                quot = (64'(clk_hz) + (denom >> 1)) / denom;
                if (quot != 0 && quot - 1 <= DEF_DIVISOR_LIMIT) begin
                    choice.found = 1'b1;
                    choice.sel   = prescale_e'(s);
                    choice.div   = DIV_W'(quot - 1);
                end
            end
        end
        return choice;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic void push_request(input logic [BAUD_W-1:0] baud);
        pending_t item;
        item.kind  = ITEM_REQUEST;
        item.value = baud;
        item.gap   = pick_gap();
        pending_q.push_back(item);
    endfunction

    function automatic void push_marker(input item_kind_e kind, input logic [31:0] value);
        pending_t item;
        item.kind  = kind;
        item.value = value;
        item.gap   = 0;
        pending_q.push_back(item);
    endfunction

    // Aims at a divisor near a chosen value for a random prescaler, so most requests land
    // in range or just past its edges.
    function automatic logic [BAUD_W-1:0] aimed_baud(input logic [CLK_W-1:0] clk_hz);
        int unsigned sel_idx;
        logic [63:0] div_target;
        logic [63:0] span;
        logic [63:0] b;
        sel_idx = $urandom_range(0, MAX_PRESCALE - 1);
        if ($urandom_range(0, 3) == 0) div_target = $urandom_range(254, 258);
        else div_target = $urandom_range(1, 258);
        span = div_target << (FACTOR_BASE_LOG2 + 2 * sel_idx);
        b = 64'(clk_hz) / span;
        case ($urandom_range(0, 2))
            0: b = b + 1;
            1: if (b > 0) b = b - 1;
            default: ;
        endcase
        return b[BAUD_W-1:0];
    endfunction

    function automatic logic [BAUD_W-1:0] random_baud(input logic [CLK_W-1:0] clk_hz);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return aimed_baud(clk_hz);
        if (r < 80) return $urandom;
        if (r < 90) return $urandom >> $urandom_range(0, 31);
        if (r < 95) return $urandom_range(1, 4000000);
        case ($urandom_range(0, 2))
            0: return '0;
            1: return 1;
            default: return '1;
        endcase
    endfunction

    always @(posedge i_clk) begin : drive_requests
        logic              n_start;
        logic              n_cfg_en;
        logic [BAUD_W-1:0] n_baud;
        logic [CLK_W-1:0]  n_cfg_data;
        pending_t          item;
        n_start    = start;
        n_cfg_en   = 1'b0;
        n_baud     = i_baud_rate;
        n_cfg_data = i_cfg_wr_data;
        if (!i_rst_n) begin
            n_start      = 1'b0;
            model_clk_hz = CLK_HZ_RESET;
            gap_left     = 0;
        end else begin
            if (i_cfg_wr_en) model_clk_hz = i_cfg_wr_data;
            if (start && !busy) begin
                expected_q.push_back(solve_divisor(model_clk_hz, i_baud_rate));
                requests_sent++;
                n_start  = 1'b0;
                gap_left = issued_gap;
            end
            if (!n_start) begin
                if (gap_left > 0 || pending_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    n_baud = $urandom;
                end else begin
                    item = pending_q[0];
                    case (item.kind)
                        ITEM_REQUEST: begin
                            n_start    = 1'b1;
                            n_baud     = item.value;
                            issued_gap = item.gap;
                            pending_q.delete(0);
                        end
                        ITEM_CLOCK_WRITE: begin
                            if (expected_q.size() == 0) begin
                                n_cfg_en   = 1'b1;
                                n_cfg_data = item.value;
                                clock_writes++;
                                pending_q.delete(0);
                            end
                        end
                        default: begin
                            if (expected_q.size() == 0) begin
                                drains_done++;
                                pending_q.delete(0);
                            end
                        end
                    endcase
                end
            end
        end
        start         <= n_start;
        i_cfg_wr_en   <= n_cfg_en;
        i_baud_rate   <= n_baud;
        i_cfg_wr_data <= n_cfg_data;
    end

    always @(posedge i_clk) begin : check_results
        divisor_choice_t want;
        if (i_rst_n && o_result_valid) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: found=%0b select=%0d divisor=%0d",
                       o_found, o_prescale_select, o_divisor_value);
                fail_cnt++;
            end else begin
                want = expected_q.pop_front();
                results_seen++;
                if (want.found) found_seen++;
                if (o_found !== want.found) begin
                    $error("found: expected %0b, actual %0b", want.found, o_found);
                    fail_cnt++;
                end
                if (o_prescale_select !== want.sel) begin
                    $error("prescale_select: expected %0d, actual %0d",
                           want.sel, o_prescale_select);
                    fail_cnt++;
                end
                if (o_divisor_value !== want.div) begin
                    $error("divisor_value: expected %0d, actual %0d",
                           want.div, o_divisor_value);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || i_cfg_wr_en) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Run stalled with %0d results outstanding.", expected_q.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [CLK_W-1:0] clocks[8];
        logic [CLK_W-1:0] directed[$];

        // The reset clock of 48 MHz covers typical rates, the edges of each prescaler
        // and a clock too fast for a slow request.
        directed = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'd9600, 32'd115200,
                     32'd1200, 32'd300, 32'd2400, 32'd1500000, 32'd3000000, 32'd1000000,
                     32'd5860, 32'd5859, 32'd1465, 32'd1464, 32'd367, 32'd366, 32'd92,
                     32'd91, 32'd45, 32'd230400};
        foreach (directed[k]) push_request(directed[k]);
        push_marker(ITEM_DRAIN, '0);

        clocks = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1843200, 32'd16000000, 32'd100000000,
                   CLK_W'($urandom), CLK_W'($urandom_range(1000, 2000000))};
        foreach (clocks[p]) begin
            push_marker(ITEM_CLOCK_WRITE, clocks[p]);
            push_request('0);
            push_request('1);
            push_request(1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) calm = ($urandom_range(0, 2) == 0);
                if (n == PHASE_ITEMS / 2) push_marker(ITEM_DRAIN, '0);
                push_request(random_baud(clocks[p]));
            end
            push_marker(ITEM_DRAIN, '0);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            fail_cnt++;
        end
        $display("Covered %0d requests under %0d clock settings besides the reset one.",
                 requests_sent, clock_writes);
        $display("Checked %0d results, %0d with a divisor found, across %0d pipeline drains.",
                 results_seen, found_seen, drains_done);
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- uart_baud_divisor_solver_unit.f -----
+incdir+src
src/uart_bds_pkg.sv
src/uart_baud_divisor_solver_unit.sv
tb/tb_uart_baud_divisor_solver_unit.sv
